// ===== src/ffsa_pkg.sv =====
// ffsa_pkg: request, result and cell command types of the first-fit segment allocator
// no dependencies; imported by ffsa_cell and first_fit_segment_allocator
`default_nettype none

package ffsa_pkg;

  localparam int IDX_W   = 4;
  localparam int DATA_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int COUNT_W = 5;
  localparam int MAX_SEG = 16;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  segment_index;
    logic [DATA_W-1:0] size;
  } ffsa_in_t;

  typedef struct packed {
    logic               granted;
    logic [IDX_W-1:0]   chosen_segment;
    logic [DATA_W-1:0]  remaining_free;
    logic [TOTAL_W-1:0] fragment_total;
  } ffsa_out_t;

  typedef struct packed {
    logic              load;
    logic              search;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] size;
  } ffsa_cmd_t;

endpackage

`default_nettype wire

// ===== src/ffsa_cell.sv =====
// ffsa_cell: one segment of the allocator, holds its free size and joins the first-fit chain
// depends on ffsa_pkg
`default_nettype none

module ffsa_cell #(
  parameter int SIZE_BITS = 16,
  parameter int CELL_ID   = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffsa_pkg::ffsa_cmd_t           cmd_i,
  input  wire logic [ffsa_pkg::COUNT_W-1:0]  count_i,
  input  wire logic                          taken_i,
  input  wire logic [SIZE_BITS-1:0]          left_i,
  input  wire logic [ffsa_pkg::IDX_W-1:0]    idx_i,
  output logic                               taken_o,
  output logic [SIZE_BITS-1:0]               left_o,
  output logic [ffsa_pkg::IDX_W-1:0]         idx_o
);
  import ffsa_pkg::*;

  localparam int CW = (SIZE_BITS > DATA_W) ? SIZE_BITS : DATA_W;

  logic [SIZE_BITS-1:0] free_q, free_d;
  logic [CW-1:0]        size_x, free_x, diff;
  logic                 active, fit, hit, load_me;

  always_comb begin
    size_x  = CW'(cmd_i.size);
    free_x  = CW'(free_q);
    diff    = free_x - size_x;
    active  = COUNT_W'(CELL_ID) < count_i;
    fit     = cmd_i.search && active && (size_x <= free_x);
    hit     = fit && !taken_i;
    load_me = cmd_i.load && (cmd_i.idx == IDX_W'(CELL_ID));
    taken_o = taken_i || fit;
    left_o  = left_i | (hit ? diff[SIZE_BITS-1:0] : '0);
    idx_o   = idx_i | (hit ? IDX_W'(CELL_ID) : '0);
    free_d  = free_q;
    if (load_me) begin
      free_d = size_x[SIZE_BITS-1:0];
    end else if (hit) begin
      free_d = diff[SIZE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
    end else begin
      free_q <= free_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/first_fit_segment_allocator.sv =====
// first_fit_segment_allocator: top level, request staging, cell chain and fragmentation total
// depends on ffsa_pkg and ffsa_cell
`default_nettype none

// usage
//   a request is taken at a rising edge with start high and busy low; mode 0 loads the
//   free size of one segment, mode 1 asks for a first-fit allocation of size
//   the user writes the segment_count register through cfg_we_i / cfg_wdata_i only while
//   idle, the block itself does not enforce it; each request gives one result on res_o, marked
//   by done_o for a single cycle; timing: accept registers the request and raises busy;
//   while busy the row of cells compares the size against every active segment, the
//   priority chain through the cells picks the lowest fitting one and that cell writes
//   back its new free size as the staging registers capture the result; from them the
//   saturating fragmentation total is updated and res_o and done_o are registered
//   busy is high for one cycle after each accept, and no new request is taken while busy
//   the cell chain sets the cycle time: one compare per cell plus a 16-deep chain
//   reset clears the total, the segment count, the segment free sizes and the
//   strobes; the receiver cannot stall, results are not held
module first_fit_segment_allocator #(
  parameter int NSEG      = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ffsa_pkg::ffsa_in_t            req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ffsa_pkg::COUNT_W-1:0]  cfg_wdata_i,
  output logic                               done_o,
  output ffsa_pkg::ffsa_out_t                res_o
);
  import ffsa_pkg::*;

  localparam int NCELL = (NSEG < MAX_SEG) ? NSEG : MAX_SEG;
  localparam int CW    = (SIZE_BITS > DATA_W) ? SIZE_BITS : DATA_W;

  logic                 work_q;
  ffsa_in_t             req_q;
  logic [COUNT_W-1:0]   count_q;
  ffsa_cmd_t            cmd;

  logic                 taken [NCELL+1];
  logic [SIZE_BITS-1:0] left  [NCELL+1];
  logic [IDX_W-1:0]     idx   [NCELL+1];

  logic                 st_valid_q;
  logic                 st_granted_q, st_granted_d;
  logic [IDX_W-1:0]     st_idx_q, st_idx_d;
  logic [SIZE_BITS-1:0] st_left_q, st_left_d;
  logic [CW-1:0]        st_amount_q, st_amount_d;

  logic [TOTAL_W-1:0]   acc_q, acc_d;
  logic [TOTAL_W:0]     sum;
  logic [CW-1:0]        size_x;
  logic                 load_ok;

  assign busy = work_q;

  always_comb begin
    cmd.load   = work_q && (req_q.mode == MODE_LOAD);
    cmd.search = work_q && (req_q.mode == MODE_REQUEST);
    cmd.idx    = req_q.segment_index;
    cmd.size   = req_q.size;
  end

  assign taken[0] = 1'b0;
  assign left[0]  = '0;
  assign idx[0]   = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ffsa_cell #(
      .SIZE_BITS(SIZE_BITS),
      .CELL_ID  (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .count_i(count_q),
      .taken_i(taken[i]),
      .left_i (left[i]),
      .idx_i  (idx[i]),
      .taken_o(taken[i+1]),
      .left_o (left[i+1]),
      .idx_o  (idx[i+1])
    );
  end

  always_comb begin
    size_x       = CW'(req_q.size);
    load_ok      = (COUNT_W'(req_q.segment_index) < COUNT_W'(NCELL));
    st_granted_d = 1'b0;
    st_idx_d     = '0;
    st_left_d    = '0;
    st_amount_d  = '0;
    if (req_q.mode == MODE_LOAD) begin
      if (load_ok) begin
        st_idx_d  = req_q.segment_index;
        st_left_d = size_x[SIZE_BITS-1:0];
      end
    end else if (taken[NCELL]) begin
      st_granted_d = 1'b1;
      st_idx_d     = idx[NCELL];
      st_left_d    = left[NCELL];
      st_amount_d  = CW'(left[NCELL]);
    end else begin
      st_amount_d  = size_x;
    end
    sum   = {1'b0, acc_q} + (TOTAL_W+1)'(st_amount_q);
    acc_d = acc_q;
    if (st_valid_q) begin
      acc_d = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q     <= 1'b0;
      st_valid_q <= 1'b0;
      done_o     <= 1'b0;
      count_q    <= '0;
      acc_q      <= '0;
    end else begin
      work_q     <= start && !work_q;
      st_valid_q <= work_q;
      done_o     <= st_valid_q;
      acc_q      <= acc_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !work_q) begin
      req_q <= req_i;
    end
    if (work_q) begin
      st_granted_q <= st_granted_d;
      st_idx_q     <= st_idx_d;
      st_left_q    <= st_left_d;
      st_amount_q  <= st_amount_d;
    end
    if (st_valid_q) begin
      res_o.granted        <= st_granted_q;
      res_o.chosen_segment <= st_idx_q;
      res_o.remaining_free <= DATA_W'(CW'(st_left_q));
      res_o.fragment_total <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== bench/first_fit_segment_allocator_test.sv =====
// first_fit_segment_allocator_test: self-checking bench for the first-fit segment allocator
// depends on ffsa_pkg and first_fit_segment_allocator; a scoreboard class predicts each result
// from its own copy of the segment table, plain tasks drive requests and the count register

class first_fit_tracker;
  logic [ffsa_pkg::DATA_W-1:0]  seg_free [ffsa_pkg::MAX_SEG];
  logic [ffsa_pkg::TOTAL_W-1:0] frag_total;
  logic [ffsa_pkg::COUNT_W-1:0] active_count;
  ffsa_pkg::ffsa_out_t          awaited_outcomes [$];
  int                           mismatches;
  int                           loads;
  int                           grants;
  int                           refusals;
  int                           saturated_hits;

  function new();
    foreach (seg_free[k]) seg_free[k] = '0;
    frag_total     = '0;
    active_count   = '0;
    mismatches     = 0;
    loads          = 0;
    grants         = 0;
    refusals       = 0;
    saturated_hits = 0;
  endfunction

  function void add_to_total(logic [ffsa_pkg::DATA_W-1:0] amount);
    logic [ffsa_pkg::TOTAL_W:0] sum;
    sum = {1'b0, frag_total} + amount;
    frag_total = sum[ffsa_pkg::TOTAL_W] ? '1 : sum[ffsa_pkg::TOTAL_W-1:0];
  endfunction

  function void note_request(ffsa_pkg::ffsa_in_t item);
    ffsa_pkg::ffsa_out_t outcome;
    int                  searched;
    int                  j;
    bit                  found;
    outcome = '0;
    found   = 1'b0;
    if (item.mode == ffsa_pkg::MODE_LOAD) begin
      seg_free[item.segment_index] = item.size;
      outcome.chosen_segment       = item.segment_index;
      outcome.remaining_free       = item.size;
      loads++;
    end else begin
      searched = (active_count > ffsa_pkg::MAX_SEG) ? ffsa_pkg::MAX_SEG : int'(active_count);
      for (j = 0; j < searched && !found; j++) begin
        if (item.size <= seg_free[j]) begin
          seg_free[j] = seg_free[j] - item.size;
          add_to_total(seg_free[j]);
          outcome.granted        = 1'b1;
          outcome.chosen_segment = j[ffsa_pkg::IDX_W-1:0];
          outcome.remaining_free = seg_free[j];
          found                  = 1'b1;
        end
      end
      if (found) begin
        grants++;
      end else begin
        add_to_total(item.size);
        refusals++;
      end
      if (frag_total == '1) saturated_hits++;
    end
    outcome.fragment_total = frag_total;
    awaited_outcomes.push_back(outcome);
  endfunction

  function void check_outcome(ffsa_pkg::ffsa_out_t actual);
    ffsa_pkg::ffsa_out_t want;
    if (awaited_outcomes.size() == 0) begin
      $error("result with no request outstanding: %p", actual);
      mismatches++;
      return;
    end
    want = awaited_outcomes.pop_front();
    if (actual.granted !== want.granted) begin
      $error("granted: expected %0d, got %0d", want.granted, actual.granted);
      mismatches++;
    end
    if (actual.chosen_segment !== want.chosen_segment) begin
      $error("chosen_segment: expected %0d, got %0d", want.chosen_segment,
             actual.chosen_segment);
      mismatches++;
    end
    if (actual.remaining_free !== want.remaining_free) begin
      $error("remaining_free: expected %0d, got %0d", want.remaining_free,
             actual.remaining_free);
      mismatches++;
    end
    if (actual.fragment_total !== want.fragment_total) begin
      $error("fragment_total: expected %0d, got %0d", want.fragment_total,
             actual.fragment_total);
      mismatches++;
    end
  endfunction
endclass

module first_fit_segment_allocator_test;
  import ffsa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  ffsa_in_t              req_i;
  logic                  cfg_we_i;
  logic [COUNT_W-1:0]    cfg_wdata_i;
  logic                  done_o;
  ffsa_out_t             res_o;

  first_fit_tracker      board;
  bit                    quiet;
  int                    cycle_count;
  int                    count_writes;

  first_fit_segment_allocator #(
    .NSEG      (16),
    .SIZE_BITS (16)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_outcome(res_o);
  end

  function automatic logic [DATA_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(0, 255));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic ffsa_in_t load_item(int idx, logic [DATA_W-1:0] sz);
    ffsa_in_t item;
    item.mode          = MODE_LOAD;
    item.segment_index = IDX_W'(idx);
    item.size          = sz;
    return item;
  endfunction

  function automatic ffsa_in_t alloc_item(logic [DATA_W-1:0] sz);
    ffsa_in_t item;
    item.mode          = MODE_REQUEST;
    item.segment_index = IDX_W'($urandom);
    item.size          = sz;
    return item;
  endfunction

  // request size aimed at the current table, so most requests find a home
  function automatic logic [DATA_W-1:0] fitting_size();
    int searched;
    int j;
    searched = (board.active_count > MAX_SEG) ? MAX_SEG : int'(board.active_count);
    if (searched == 0) return pick_size();
    j = $urandom_range(0, searched - 1);
    case ($urandom_range(0, 3))
      0:       return board.seg_free[j];
      1:       return DATA_W'($urandom_range(0, 64));
      default: return DATA_W'($urandom_range(0, int'(board.seg_free[j])));
    endcase
  endfunction

  task automatic send_item(input ffsa_in_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_request(item);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.active_count = value;
    count_writes++;
  endtask

  task automatic random_phase(input int items);
    int       k;
    ffsa_in_t item;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 31) == 0) quiet = ~quiet;
      if ($urandom_range(0, 99) < 35) begin
        item = load_item($urandom_range(0, MAX_SEG - 1), pick_size());
      end else if ($urandom_range(0, 99) < 70) begin
        item = alloc_item(fitting_size());
      end else begin
        item = alloc_item(pick_size());
      end
      send_item(item);
    end
  endtask

  initial begin
    int                 k;
    int                 phase;
    logic [COUNT_W-1:0] setting;
    board        = new();
    quiet        = 1'b0;
    cycle_count  = 0;
    count_writes = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no active segment: every request refused, loads fill the whole table
    write_count(5'd0);
    send_item(alloc_item(16'd0));
    send_item(alloc_item(16'hFFFF));
    send_item(load_item(0, 16'd0));
    send_item(load_item(1, 16'hFFFF));
    for (k = 2; k < MAX_SEG - 1; k++) send_item(load_item(k, DATA_W'(k * 100)));
    send_item(load_item(MAX_SEG - 1, 16'hFFFF));

    // zero request into an empty segment, then a one-unit refusal
    write_count(5'd1);
    send_item(alloc_item(16'd0));
    send_item(alloc_item(16'd1));

    // exact fit at full width
    write_count(5'd16);
    send_item(alloc_item(16'hFFFF));
    send_item(alloc_item(16'd0));

    // oversized count clamps to the table, only the last segment fits the first request, the second is refused
    write_count(5'd31);
    send_item(alloc_item(16'd65000));
    send_item(alloc_item(16'd60000));

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       setting = 5'd16;
        1:       setting = 5'd0;
        2:       setting = 5'd31;
        3:       setting = 5'd1;
        4:       setting = 5'd17;
        default: setting = COUNT_W'($urandom_range(0, 31));
      endcase
      write_count(setting);
      random_phase(52);
    end

    write_count(5'd16);
    random_phase(30);

    drain();
    $display("covered %0d loads, %0d grants and %0d refusals over %0d count settings",
             board.loads, board.grants, board.refusals, count_writes);
    $display("total held at its ceiling after %0d requests", board.saturated_hits);
    if (board.mismatches == 0 && board.awaited_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
